@@ rtl/core/video_unit_cpu_register_port_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef VIDEO_UNIT_CPU_REGISTER_PORT_MACROS_SVH
`define VIDEO_UNIT_CPU_REGISTER_PORT_MACROS_SVH

// Same-cycle implication, skipped while the disable condition holds.
`define VUCRP_ASSERT_IMPL(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("vucrp: same-cycle check failed");

// Next-cycle implication, skipped while the disable condition holds.
`define VUCRP_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("vucrp: next-cycle check failed");

`endif

@@ rtl/core/vucrp_pkg.sv @@
`default_nettype none

package vucrp_pkg;

   // Item kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FLAGS = 2'd2;

   // CPU register numbers
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_MASK    = 3'd1;
   localparam logic [2:0] REG_STATUS  = 3'd2;
   localparam logic [2:0] REG_SCROLL  = 3'd5;
   localparam logic [2:0] REG_ADDRESS = 3'd6;
   localparam logic [2:0] REG_DATA    = 3'd7;

   // Address constants
   localparam logic [13:0] PALETTE_BASE = 14'h3F00;
   localparam logic [14:0] ROW_STEP     = 15'd32;
   localparam logic [14:0] COL_STEP     = 15'd1;

   // Status flag bits
   localparam int unsigned FLAG_VBLANK = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] reg_index;
      logic [7:0] write_value;
      logic [7:0] memory_byte;
      logic [2:0] new_flags;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic        read_driven;
      logic        mem_write;
      logic [13:0] mem_address;
      logic [7:0]  mem_write_value;
      logic [14:0] current_address;
      logic [14:0] temporary_address;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  control_value;
      logic [7:0]  mask_value;
   } rsp_item_type;

   // Handshake state of the input stage toward the core
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/vucrp_ifs.sv @@
`default_nettype none

interface vucrp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] reg_index;
   logic [7:0] write_value;
   logic [7:0] memory_byte;
   logic [2:0] new_flags;

   modport source (output valid, kind, reg_index, write_value, memory_byte, new_flags,
                   input ready);
   modport sink   (input valid, kind, reg_index, write_value, memory_byte, new_flags,
                   output ready);
endinterface

interface vucrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_value;
   logic        read_driven;
   logic        mem_write;
   logic [13:0] mem_address;
   logic [7:0]  mem_write_value;
   logic [14:0] current_address;
   logic [14:0] temporary_address;
   logic [2:0]  fine_scroll_x;
   logic [7:0]  control_value;
   logic [7:0]  mask_value;

   modport source (output valid, read_value, read_driven, mem_write, mem_address,
                   mem_write_value, current_address, temporary_address, fine_scroll_x,
                   control_value, mask_value,
                   input ready);
   modport sink   (input valid, read_value, read_driven, mem_write, mem_address,
                   mem_write_value, current_address, temporary_address, fine_scroll_x,
                   control_value, mask_value,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/vucrp_in_stage.sv @@
`default_nettype none

module vucrp_in_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire vucrp_pkg::req_item_type req_item,
   input  wire                          advance,
   output logic                         item_valid,
   output vucrp_pkg::req_item_type      item
);

   logic                    valid_ff, valid_in;
   vucrp_pkg::req_item_type item_ff,  item_in;

   // Take a new item whenever the slot is empty or drains this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ rtl/core/vucrp_core.sv @@
`default_nettype none

module vucrp_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire vucrp_pkg::stage_ctrl_type ctrl,
   input  wire vucrp_pkg::req_item_type   item,
   output vucrp_pkg::rsp_item_type        result
);

   logic [7:0]  control_ff, control_in;
   logic [7:0]  mask_ff,    mask_in;
   logic [2:0]  flags_ff,   flags_in;
   logic [14:0] temp_ff,    temp_in;
   logic [14:0] cur_ff,     cur_in;
   logic [2:0]  finex_ff,   finex_in;
   logic        toggle_ff,  toggle_in;
   logic [7:0]  rbuf_ff,    rbuf_in;

   logic [14:0] cur_step;
   logic [13:0] access_addr;
   logic [7:0]  v;
   logic [7:0]  rval;
   logic        rdrv;
   logic        mwr;
   logic [13:0] maddr;
   logic [7:0]  mwval;

   // Step the current address by one column or one row
   assign cur_step    = cur_ff + (control_ff[2] ? vucrp_pkg::ROW_STEP : vucrp_pkg::COL_STEP);
   assign access_addr = cur_ff[13:0];
   assign v           = item.write_value;

   // Decode one item into next state and result fields
   always_comb begin
      control_in = control_ff;
      mask_in    = mask_ff;
      flags_in   = flags_ff;
      temp_in    = temp_ff;
      cur_in     = cur_ff;
      finex_in   = finex_ff;
      toggle_in  = toggle_ff;
      rbuf_in    = rbuf_ff;
      rval       = 8'd0;
      rdrv       = 1'b0;
      mwr        = 1'b0;
      maddr      = 14'd0;
      mwval      = 8'd0;
      unique case (item.kind)
         vucrp_pkg::KIND_WRITE: begin
            unique case (item.reg_index)
               vucrp_pkg::REG_CONTROL: begin
                  control_in     = v;
                  temp_in[11:10] = v[1:0];
               end
               vucrp_pkg::REG_MASK: begin
                  mask_in = v;
               end
               vucrp_pkg::REG_SCROLL: begin
                  if (toggle_ff) begin
                     temp_in[9:5]   = v[7:3];
                     temp_in[14:12] = v[2:0];
                  end else begin
                     temp_in[4:0] = v[7:3];
                     finex_in     = v[2:0];
                  end
                  toggle_in = !toggle_ff;
               end
               vucrp_pkg::REG_ADDRESS: begin
                  if (toggle_ff) begin
                     temp_in[7:0] = v;
                     cur_in       = {temp_ff[14:8], v};
                  end else begin
                     temp_in[13:8] = v[5:0];
                     temp_in[14]   = 1'b0;
                  end
                  toggle_in = !toggle_ff;
               end
               vucrp_pkg::REG_DATA: begin
                  mwr    = 1'b1;
                  maddr  = access_addr;
                  mwval  = v;
                  cur_in = cur_step;
               end
               default: begin
               end
            endcase
         end
         vucrp_pkg::KIND_READ: begin
            unique case (item.reg_index)
               vucrp_pkg::REG_STATUS: begin
                  rval                            = {flags_ff, 5'd0};
                  rdrv                            = 1'b1;
                  flags_in[vucrp_pkg::FLAG_VBLANK] = 1'b0;
                  toggle_in                       = 1'b0;
               end
               vucrp_pkg::REG_DATA: begin
                  maddr   = access_addr;
                  // Palette bytes bypass the read buffer
                  rval    = (access_addr >= vucrp_pkg::PALETTE_BASE) ? item.memory_byte
                                                                     : rbuf_ff;
                  rdrv    = 1'b1;
                  rbuf_in = item.memory_byte;
                  cur_in  = cur_step;
               end
               default: begin
               end
            endcase
         end
         vucrp_pkg::KIND_FLAGS: begin
            flags_in = item.new_flags;
         end
         default: begin
         end
      endcase
   end

   // Commit state only when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= 8'd0;
         mask_ff    <= 8'd0;
         flags_ff   <= 3'd0;
         temp_ff    <= 15'd0;
         cur_ff     <= 15'd0;
         finex_ff   <= 3'd0;
         toggle_ff  <= 1'b0;
         rbuf_ff    <= 8'd0;
      end else if (ctrl.valid && ctrl.advance) begin
         control_ff <= control_in;
         mask_ff    <= mask_in;
         flags_ff   <= flags_in;
         temp_ff    <= temp_in;
         cur_ff     <= cur_in;
         finex_ff   <= finex_in;
         toggle_ff  <= toggle_in;
         rbuf_ff    <= rbuf_in;
      end
   end

   always_comb begin
      result.read_value        = rval;
      result.read_driven       = rdrv;
      result.mem_write         = mwr;
      result.mem_address       = maddr;
      result.mem_write_value   = mwval;
      result.current_address   = cur_in;
      result.temporary_address = temp_in;
      result.fine_scroll_x     = finex_in;
      result.control_value     = control_in;
      result.mask_value        = mask_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/video_unit_cpu_register_port.sv @@
`default_nettype none

// CPU register port of a tile video unit with loopy scroll registers. Each item on
// req_chan is one CPU register write, one CPU register read, or a status flag update
// from the renderer, and gives exactly one item on rsp_chan. The block takes one item
// every clock when rsp_chan keeps up. An item waits in the input register until the
// result register is free or being emptied, then moves to the result register, from
// which it is offered on rsp_chan. Data reads present the current video memory byte
// with the request (memory_byte); the returned mem_address tells which address
// that byte belonged to. Control, mask, scroll and address state is reported after
// every item.
module video_unit_cpu_register_port (
   input  wire        clock,
   input  wire        reset,
   vucrp_req_if.sink  req_chan,
   vucrp_rsp_if.source rsp_chan
);

   vucrp_pkg::req_item_type   req_item;
   vucrp_pkg::req_item_type   item;
   vucrp_pkg::rsp_item_type   result;
   vucrp_pkg::rsp_item_type   rsp_data_ff, rsp_data_in;
   vucrp_pkg::stage_ctrl_type ctrl;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      item_valid;
   logic                      advance;
   logic                      req_ready;

   assign req_item.kind        = req_chan.kind;
   assign req_item.reg_index   = req_chan.reg_index;
   assign req_item.write_value = req_chan.write_value;
   assign req_item.memory_byte = req_chan.memory_byte;
   assign req_item.new_flags   = req_chan.new_flags;
   assign req_chan.ready       = req_ready;

   // Move an item on when the result register is free or being emptied
   assign advance      = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign ctrl.valid   = item_valid;
   assign ctrl.advance = advance;

   vucrp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vucrp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .result (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.read_value        = rsp_data_ff.read_value;
   assign rsp_chan.read_driven       = rsp_data_ff.read_driven;
   assign rsp_chan.mem_write         = rsp_data_ff.mem_write;
   assign rsp_chan.mem_address       = rsp_data_ff.mem_address;
   assign rsp_chan.mem_write_value   = rsp_data_ff.mem_write_value;
   assign rsp_chan.current_address   = rsp_data_ff.current_address;
   assign rsp_chan.temporary_address = rsp_data_ff.temporary_address;
   assign rsp_chan.fine_scroll_x     = rsp_data_ff.fine_scroll_x;
   assign rsp_chan.control_value     = rsp_data_ff.control_value;
   assign rsp_chan.mask_value        = rsp_data_ff.mask_value;

endmodule

`default_nettype wire

@@ rtl/core/vucrp_checker.sv @@
`default_nettype none

`include "video_unit_cpu_register_port_macros.svh"

module vucrp_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  read_value,
   input wire        read_driven,
   input wire        mem_write,
   input wire [13:0] mem_address,
   input wire [7:0]  mem_write_value,
   input wire [14:0] current_address
);

   // Hold a stalled item
   `VUCRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(mem_address) && $stable(current_address))

   // Drop everything on reset
   `VUCRP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Undriven read bus and idle write port carry zeros
   `VUCRP_ASSERT_IMPL(a_idle_zero, clock, reset, rsp_valid && !read_driven, read_value == 8'd0 && (mem_write || mem_write_value == 8'd0))

   // A data write never also returns a read byte
   `VUCRP_ASSERT_IMPL(a_write_no_read, clock, reset, rsp_valid && mem_write, !read_driven)

   // A data write leaves the address stepped by one column or one row
   `VUCRP_ASSERT_IMPL(a_addr_step, clock, reset, rsp_valid && mem_write, current_address[13:0] == mem_address + 14'd1 || current_address[13:0] == mem_address + 14'd32)

endmodule

bind video_unit_cpu_register_port vucrp_checker u_vucrp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .read_value      (rsp_chan.read_value),
   .read_driven     (rsp_chan.read_driven),
   .mem_write       (rsp_chan.mem_write),
   .mem_address     (rsp_chan.mem_address),
   .mem_write_value (rsp_chan.mem_write_value),
   .current_address (rsp_chan.current_address)
);

`default_nettype wire

@@ sim/video_unit_cpu_register_port_test.sv @@
`timescale 1ns / 100ps

module video_unit_cpu_register_port_test;

   // Codes with no function in the block, used to check they are ignored
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] REG_SPARE_3 = 3'd3;
   localparam logic [2:0] REG_SPARE_4 = 3'd4;

   // Tracks the register file of the port and the results it must produce
   class port_state_model;
      logic [7:0]   control_reg;
      logic [7:0]   mask_reg;
      logic [2:0]   status_flags;
      logic [14:0]  temp_addr;
      logic [14:0]  current_addr;
      logic [2:0]   fine_x;
      logic         write_toggle;
      logic [7:0]   read_buffer;
      vucrp_pkg::rsp_item_type expected_rsp_q[$];
      int unsigned  errors;

      function new();
         control_reg  = '0;
         mask_reg     = '0;
         status_flags = '0;
         temp_addr    = '0;
         current_addr = '0;
         fine_x       = '0;
         write_toggle = 1'b0;
         read_buffer  = '0;
         errors       = 0;
      endfunction

      // Advance the video address by one column or one row
      function void step_address();
         current_addr = current_addr + (control_reg[2] ? vucrp_pkg::ROW_STEP
                                                       : vucrp_pkg::COL_STEP);
      endfunction

      // Apply one accepted item and queue the result it must produce
      function void note_request(vucrp_pkg::req_item_type req);
         vucrp_pkg::rsp_item_type rsp;
         logic [14:0]  t;
         rsp = '0;
         t = temp_addr;
         case (req.kind)
            vucrp_pkg::KIND_WRITE: begin
               case (req.reg_index)
                  vucrp_pkg::REG_CONTROL: begin
                     control_reg = req.write_value;
                     t[11:10] = req.write_value[1:0];
                  end
                  vucrp_pkg::REG_MASK: mask_reg = req.write_value;
                  vucrp_pkg::REG_SCROLL: begin
                     if (write_toggle) begin
                        t[14:12] = req.write_value[2:0];
                        t[9:5]   = req.write_value[7:3];
                     end else begin
                        t[4:0] = req.write_value[7:3];
                        fine_x = req.write_value[2:0];
                     end
                     write_toggle = ~write_toggle;
                  end
                  vucrp_pkg::REG_ADDRESS: begin
                     if (write_toggle) begin
                        t[7:0] = req.write_value;
                        current_addr = t;
                     end else begin
                        t[14]   = 1'b0;
                        t[13:8] = req.write_value[5:0];
                     end
                     write_toggle = ~write_toggle;
                  end
                  vucrp_pkg::REG_DATA: begin
                     rsp.mem_write       = 1'b1;
                     rsp.mem_address     = current_addr[13:0];
                     rsp.mem_write_value = req.write_value;
                     step_address();
                  end
                  default: ;
               endcase
            end
            vucrp_pkg::KIND_READ: begin
               case (req.reg_index)
                  vucrp_pkg::REG_STATUS: begin
                     rsp.read_value  = {status_flags, 5'b0};
                     rsp.read_driven = 1'b1;
                     status_flags[vucrp_pkg::FLAG_VBLANK] = 1'b0;
                     write_toggle = 1'b0;
                  end
                  vucrp_pkg::REG_DATA: begin
                     rsp.mem_address = current_addr[13:0];
                     // palette bytes bypass the read buffer
                     rsp.read_value  = (current_addr[13:0] >= vucrp_pkg::PALETTE_BASE) ?
                                       req.memory_byte : read_buffer;
                     rsp.read_driven = 1'b1;
                     read_buffer = req.memory_byte;
                     step_address();
                  end
                  default: ;
               endcase
            end
            vucrp_pkg::KIND_FLAGS: status_flags = req.new_flags;
            default: ;
         endcase
         temp_addr = t;
         rsp.current_address   = current_addr;
         rsp.temporary_address = temp_addr;
         rsp.fine_scroll_x     = fine_x;
         rsp.control_value     = control_reg;
         rsp.mask_value        = mask_reg;
         expected_rsp_q.push_back(rsp);
      endfunction

      function void check_field(string field, logic [14:0] exp_val, logic [14:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
            errors++;
         end
      endfunction

      // Compare one result with the oldest expectation
      function void check_response(vucrp_pkg::rsp_item_type rsp);
         vucrp_pkg::rsp_item_type want;
         if (expected_rsp_q.size() == 0) begin
            $error("result item with no expectation waiting");
            errors++;
            return;
         end
         want = expected_rsp_q.pop_front();
         check_field("read_value", 15'(want.read_value), 15'(rsp.read_value));
         check_field("read_driven", 15'(want.read_driven), 15'(rsp.read_driven));
         check_field("mem_write", 15'(want.mem_write), 15'(rsp.mem_write));
         check_field("mem_address", 15'(want.mem_address), 15'(rsp.mem_address));
         check_field("mem_write_value", 15'(want.mem_write_value),
                     15'(rsp.mem_write_value));
         check_field("current_address", want.current_address, rsp.current_address);
         check_field("temporary_address", want.temporary_address, rsp.temporary_address);
         check_field("fine_scroll_x", 15'(want.fine_scroll_x), 15'(rsp.fine_scroll_x));
         check_field("control_value", 15'(want.control_value), 15'(rsp.control_value));
         check_field("mask_value", 15'(want.mask_value), 15'(rsp.mask_value));
      endfunction

      function int unsigned pending();
         return expected_rsp_q.size();
      endfunction
   endclass

   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned LONG_HOLD    = 120;

   logic clock;
   logic reset;
   bit   hold_off_request;
   int unsigned steady_left;
   int unsigned effective_count;

   port_state_model port_model;

   vucrp_req_if req_chan();
   vucrp_rsp_if rsp_chan();

   video_unit_cpu_register_port u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Note accepted items and check results at the rising edge
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         port_model.note_request({req_chan.kind, req_chan.reg_index, req_chan.write_value,
                                  req_chan.memory_byte, req_chan.new_flags});
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         port_model.check_response({rsp_chan.read_value, rsp_chan.read_driven,
                                    rsp_chan.mem_write, rsp_chan.mem_address,
                                    rsp_chan.mem_write_value, rsp_chan.current_address,
                                    rsp_chan.temporary_address, rsp_chan.fine_scroll_x,
                                    rsp_chan.control_value, rsp_chan.mask_value});
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic vucrp_pkg::req_item_type make_item(logic [1:0] kind,
                                                         logic [2:0] reg_index,
                                                         logic [7:0] value);
      vucrp_pkg::req_item_type it;
      it.kind        = kind;
      it.reg_index   = reg_index;
      it.write_value = value;
      it.memory_byte = 8'($urandom_range(0, 255));
      it.new_flags   = 3'($urandom_range(0, 7));
      return it;
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic issue(vucrp_pkg::req_item_type it);
      int unsigned gap;
      if (steady_left > 0) begin
         gap = 0;
         steady_left--;
      end else begin
         gap = pick_gap();
      end
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.kind        = it.kind;
      req_chan.reg_index   = it.reg_index;
      req_chan.write_value = it.write_value;
      req_chan.memory_byte = it.memory_byte;
      req_chan.new_flags   = it.new_flags;
      do @(posedge clock); while (!req_chan.ready);
      if ((it.kind == vucrp_pkg::KIND_WRITE &&
           it.reg_index inside {vucrp_pkg::REG_CONTROL, vucrp_pkg::REG_MASK,
                                vucrp_pkg::REG_SCROLL, vucrp_pkg::REG_ADDRESS,
                                vucrp_pkg::REG_DATA}) ||
          (it.kind == vucrp_pkg::KIND_READ &&
           it.reg_index inside {vucrp_pkg::REG_STATUS, vucrp_pkg::REG_DATA}) ||
          it.kind == vucrp_pkg::KIND_FLAGS)
         effective_count++;
   endtask

   task automatic issue_with_byte(logic [1:0] kind, logic [2:0] reg_index,
                                  logic [7:0] value, logic [7:0] mbyte);
      vucrp_pkg::req_item_type it;
      it = make_item(kind, reg_index, value);
      it.memory_byte = mbyte;
      issue(it);
   endtask

   // Result side: random stalls, steady stretches and requested long hold-offs
   initial begin : rsp_side
      int unsigned gap;
      int unsigned run;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = LONG_HOLD;
            run = $urandom_range(1, 8);
         end else if ($urandom_range(0, 15) == 0) begin
            gap = 0;
            run = 60;
         end else begin
            gap = pick_gap();
            run = $urandom_range(1, 6);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
         end
         repeat (run) begin
            @(negedge clock);
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Stimulus: directed items, then random well-formed sequences and noise
   initial begin : req_side
      int unsigned choice;
      int unsigned burst;
      logic [7:0]  high_byte;
      port_model           = new();
      hold_off_request     = 1'b0;
      steady_left          = 0;
      effective_count      = 0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.kind        = '0;
      req_chan.reg_index   = '0;
      req_chan.write_value = '0;
      req_chan.memory_byte = '0;
      req_chan.new_flags   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes of control, full mask, both scroll halves
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_CONTROL, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_CONTROL, 8'h00, 8'hFF);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_MASK, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF, 8'h00);
      // status read clears the toggle
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS, 8'h00, 8'h00);
      // top of the 14-bit space, palette read, then write past it
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_DATA, 8'h00, 8'hA5);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_DATA, 8'h5A, 8'h00);
      // last address below the palette, then the palette base
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'h3E, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_DATA, 8'h00, 8'h11);
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_DATA, 8'h00, 8'h00);
      // interleave scroll and address halves to load the full 15-bit address
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'h3F, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, 8'hFF, 8'h00);
      // row step wraps the 15-bit address
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_CONTROL, 8'h04, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_DATA, 8'h00, 8'h00);
      // flags, then status reads before and after vblank clears
      issue(make_item(vucrp_pkg::KIND_FLAGS, vucrp_pkg::REG_CONTROL, 8'h00));
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS, 8'h00, 8'h00);
      issue_with_byte(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS, 8'h00, 8'h00);
      // unused registers and the unused kind
      issue_with_byte(vucrp_pkg::KIND_READ, REG_SPARE_4, 8'h00, 8'hFF);
      issue_with_byte(vucrp_pkg::KIND_WRITE, REG_SPARE_3, 8'hFF, 8'hFF);
      issue_with_byte(KIND_UNUSED, vucrp_pkg::REG_DATA, 8'hFF, 8'hFF);

      effective_count = 0;
      hold_off_request = 1'b1;
      while (effective_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) steady_left = 40;
         if (effective_count > RANDOM_ITEMS / 2 && effective_count < RANDOM_ITEMS / 2 + 8)
            hold_off_request = 1'b1;
         choice = $urandom_range(0, 99);
         if (choice < 30) begin
            // address setup followed by a burst of data accesses
            if ($urandom_range(0, 1))
               issue(make_item(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS, 8'h00));
            high_byte = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) high_byte[5:0] = 6'h3F;
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS, high_byte));
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_ADDRESS,
                            8'($urandom_range(0, 255))));
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               issue(make_item($urandom_range(0, 1) ? vucrp_pkg::KIND_READ
                                                    : vucrp_pkg::KIND_WRITE,
                               vucrp_pkg::REG_DATA, 8'($urandom_range(0, 255))));
            end
         end else if (choice < 45) begin
            if ($urandom_range(0, 1))
               issue(make_item(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS, 8'h00));
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL,
                            8'($urandom_range(0, 255))));
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_SCROLL,
                            8'($urandom_range(0, 255))));
         end else if (choice < 60) begin
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_CONTROL,
                            8'($urandom_range(0, 255))));
            issue(make_item(vucrp_pkg::KIND_WRITE, vucrp_pkg::REG_MASK,
                            8'($urandom_range(0, 255))));
         end else if (choice < 75) begin
            issue(make_item(vucrp_pkg::KIND_FLAGS, 3'($urandom_range(0, 7)),
                            8'($urandom_range(0, 255))));
            burst = $urandom_range(1, 2);
            repeat (burst) issue(make_item(vucrp_pkg::KIND_READ, vucrp_pkg::REG_STATUS,
                                           8'($urandom_range(0, 255))));
         end else begin
            // noise: any kind, any register, any content
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               issue(make_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255))));
            end
         end
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (port_model.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (port_model.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
